FILE: rtl/core/gbc_pkg.sv
// Shared constants and types for the accelerometer gravity and bias calibrator.
// Depends on nothing; imported by rtl/core/accel_gravity_bias_calibrator.sv.
package gbc_pkg;

   // Default ring size and number of entries dropped when the limit is passed.
   localparam int RING_DEPTH_DEF = 1024;
   localparam int DROP_COUNT_DEF = 100;

   // Reset value of the sample limit register.
   localparam logic [9:0] LIMIT_RESET = 10'd100;

   // Gravity, 9.81 in Q16.16, and one in Q2.14.
   localparam logic signed [31:0] GRAV_Q16 = 32'sd642908;
   localparam int                 ONE_Q14  = 16384;

   // Field widths.
   localparam int KIND_W = 2;
   localparam int ACC_W  = 32;
   localparam int ROT_W  = 16;
   localparam int BIAS_W = 32;

   // Event codes carried in tuser of the request channel.
   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_START  = 2'd1,
      KIND_STOP   = 2'd2,
      KIND_CALIB  = 2'd3
   } kind_type;

endpackage

FILE: rtl/core/accel_gravity_bias_calibrator.sv
// Top level of the accelerometer gravity and bias calibrator: sample ring memory,
// calibration sequencer with a shared multiplier, divider and square root unit.
// Depends on rtl/core/gbc_pkg.sv.
//
//  channel  | direction | tdata / tuser                              | handshake
//  ---------+-----------+--------------------------------------------+------------------
//  req_     | in        | tdata: accel_x, accel_y, accel_z; tuser: kind | tvalid / tready
//  rsp_     | out       | tdata: rot_00..rot_22, bias_x..bias_z       | tvalid / tready
//  csr_     | in        | wr_data: sample_limit                      | wr_en, no wait
//
// A start, stop or calibrate transaction is handled in the idle state; a sample also
// passes through the emit state. A sample that triggers calibration walks the ring
// held in one memory read port; each stored sample costs a 32-step square root and
// three 64-step divisions in the shared divider, and the newest sample adds the
// steps for the rotation and the averages. Intake stalls meanwhile.
// Reset is synchronous; the ring contents need no clearing. A result waits in
// the output register while the next transaction is taken.
module accel_gravity_bias_calibrator
   import gbc_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int DROP_COUNT = DROP_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request: tdata = accel_x [31:0], accel_y [63:32], accel_z [95:64].
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,
   // Request: tuser = kind [1:0].
   input  logic [1:0]   req_tuser,
   // Response: tdata = rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20,
   // rot_21, rot_22 (16 bits each from bit 0), bias_x [175:144],
   // bias_y [207:176], bias_z [239:208].
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [239:0] rsp_tdata,
   // Configuration: sample_limit.
   input  logic         csr_wr_en,
   input  logic [9:0]   csr_wr_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH);
   localparam int CMP_W = (CNT_W + 1 >= 11) ? CNT_W + 1 : 11;
   localparam int SUM_W = ACC_W + 1 + CNT_W;

   typedef enum logic [5:0] {
      S_IDLE, S_EMIT, S_CAL_START, S_RD, S_LOAD, S_SQ_Y, S_SQ_Z, S_SQ_X, S_SQ_SUM,
      S_SQRT, S_DIV, S_N_CHK, S_B_MUL, S_B_DIV, S_B_ACC, S_M_SQRT, S_M_CHK,
      S_Z_DIV, S_Z_ACC, S_W_DIV, S_W_ACC, S_X0_DIV, S_X0_ACC, S_X1_MUL, S_X1_ACC,
      S_X2_ACC, S_Y_MUL1, S_Y_MUL2, S_Y_ACC, S_A_DIV, S_A_ACC, S_CAL_END
   } state_type;

   // Truncating division by 16384 toward zero.
   function automatic logic signed [64:0] trunc14(input logic signed [64:0] v);
      logic signed [64:0] t;
      begin
         t = v + ((v < 0) ? 65'sd16383 : 65'sd0);
         return t >>> 14;
      end
   endfunction

   // Clamp to [-1, 1] in Q2.14.
   function automatic logic signed [ROT_W-1:0] clamp14(input logic signed [64:0] v);
      begin
         if (v > 65'(ONE_Q14)) return ROT_W'(ONE_Q14);
         else if (v < -65'(ONE_Q14)) return -ROT_W'(ONE_Q14);
         else return v[ROT_W-1:0];
      end
   endfunction

   // Saturate to 32 bits.
   function automatic logic signed [BIAS_W-1:0] sat32(input logic signed [64:0] v);
      begin
         if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
         else if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
         else return v[BIAS_W-1:0];
      end
   endfunction

   // Magnitude of a signed 64-bit value.
   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      begin
         return (v < 0) ? 64'(-v) : 64'(v);
      end
   endfunction

   // Control state.
   state_type               state_ff, state_in, ret_ff, ret_in;
   logic                    storing_ff, storing_in, pending_ff, pending_in;
   logic [PTR_W-1:0]        head_ff, head_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in, idx_ff, idx_in;
   logic [9:0]              limit_ff, limit_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic [1:0]              k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ROT_W-1:0] x_ff [3], x_in [3], y_ff [3], y_in [3], z_ff [3], z_in [3];
   logic signed [BIAS_W-1:0] bias_ff [3], bias_in [3];

   // Datapath state.
   logic signed [ACC_W-1:0] v_ff [3], v_in [3];
   logic signed [63:0]      prod_ff, prod_in, cross_ff, cross_in;
   logic [63:0]             sqyz_ff, sqyz_in;
   logic [31:0]             n_ff, n_in, m_ff, m_in;
   logic signed [SUM_W-1:0] sum_ff [3], sum_in [3];
   logic signed [ROT_W-1:0] wy_ff, wy_in, wz_ff, wz_in;
   logic [63:0]             dv_num_ff, dv_num_in;
   logic [32:0]             dv_rem_ff, dv_rem_in;
   logic [31:0]             dv_den_ff, dv_den_in;
   logic                    dv_neg_ff, dv_neg_in;
   logic [63:0]             sr_s_ff, sr_s_in, sr_res_ff, sr_res_in;
   logic [239:0]            rsp_data_ff, rsp_data_in;

   // Ring memory.
   logic [95:0]             ring_mem [RING_DEPTH];
   logic [95:0]             rd_data_ff;
   logic                    mem_we, mem_re;
   logic [PTR_W-1:0]        wr_addr;

   // Combinational helpers.
   logic                    in_fire;
   kind_type                kind;
   logic [PTR_W:0]          wr_sum, hd_sum;
   logic [CMP_W-1:0]        cnt1, lim, drop;
   logic signed [31:0]      mul_a, mul_b;
   logic                    mul_en;
   logic [32:0]             dv_sh;
   logic                    dv_ge;
   logic [63:0]             sr_bit;
   logic [64:0]             sr_t;
   logic signed [64:0]      q;
   logic                    rot_nz, bias_nz;

   assign in_fire    = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Write address and ring bookkeeping for a stored sample.
   always_comb begin
      wr_sum = {1'b0, head_ff} + (PTR_W + 1)'(count_ff);
      if (wr_sum >= (PTR_W + 1)'(RING_DEPTH)) wr_sum = wr_sum - (PTR_W + 1)'(RING_DEPTH);
      wr_addr = wr_sum[PTR_W-1:0];
      cnt1 = CMP_W'(count_ff) + CMP_W'(1);
      lim  = (CMP_W'(limit_ff) > CMP_W'(RING_DEPTH - 1)) ? CMP_W'(RING_DEPTH - 1)
                                                           : CMP_W'(limit_ff);
      drop = (cnt1 < CMP_W'(DROP_COUNT)) ? cnt1 : CMP_W'(DROP_COUNT);
      hd_sum = {1'b0, head_ff} + drop[PTR_W:0];
      if (hd_sum >= (PTR_W + 1)'(RING_DEPTH)) hd_sum = hd_sum - (PTR_W + 1)'(RING_DEPTH);
   end

   // Divider and square root single steps, signed quotient.
   always_comb begin
      dv_sh  = {dv_rem_ff[31:0], dv_num_ff[63]};
      dv_ge  = dv_sh >= {1'b0, dv_den_ff};
      sr_bit = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
      sr_t   = {1'b0, sr_res_ff} + {1'b0, sr_bit};
      q      = dv_neg_ff ? -$signed({1'b0, dv_num_ff}) : $signed({1'b0, dv_num_ff});
   end

   // Result is shown only while rotation and bias are both nonzero.
   always_comb begin
      rot_nz  = 1'b0;
      bias_nz = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (x_ff[i] != 0 || y_ff[i] != 0 || z_ff[i] != 0) rot_nz = 1'b1;
         if (bias_ff[i] != 0) bias_nz = 1'b1;
      end
   end

   // Sequencer next-state and datapath.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      storing_in   = storing_ff;
      pending_in   = pending_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      idx_in       = idx_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; bias_in = bias_ff;
      v_in = v_ff; sum_in = sum_ff;
      cross_in = cross_ff; sqyz_in = sqyz_ff; n_in = n_ff; m_in = m_ff;
      wy_in = wy_ff; wz_in = wz_ff;
      dv_num_in = dv_num_ff; dv_rem_in = dv_rem_ff; dv_den_in = dv_den_ff;
      dv_neg_in = dv_neg_ff; sr_s_in = sr_s_ff; sr_res_in = sr_res_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               unique case (kind)
                  KIND_START: storing_in = 1'b1;
                  KIND_STOP:  storing_in = 1'b0;
                  KIND_CALIB: pending_in = 1'b1;
                  KIND_SAMPLE: begin
                     if (storing_ff) begin
                        mem_we = 1'b1;
                        if (cnt1 > lim) begin
                           head_in  = hd_sum[PTR_W-1:0];
                           count_in = CNT_W'(cnt1 - drop);
                        end else begin
                           count_in = CNT_W'(cnt1);
                        end
                     end
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        state_in   = S_CAL_START;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            if (!(rot_nz && bias_nz)) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {bias_ff[2], bias_ff[1], bias_ff[0],
                               z_ff[2], z_ff[1], z_ff[0],
                               y_ff[2], y_ff[1], y_ff[0],
                               x_ff[2], x_ff[1], x_ff[0]};
               state_in     = S_IDLE;
            end
         end
         S_CAL_START: begin
            idx_in    = '0;
            rd_ptr_in = head_ff;
            for (int i = 0; i < 3; i++) sum_in[i] = '0;
            state_in  = (count_ff == '0) ? S_CAL_END : S_RD;
         end
         S_RD: begin
            mem_re   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            v_in[0]  = rd_data_ff[31:0];
            v_in[1]  = rd_data_ff[63:32];
            v_in[2]  = rd_data_ff[95:64];
            state_in = S_SQ_Y;
         end
         // Sum of squares: y and z first, kept for the tilt norm.
         S_SQ_Y: begin
            mul_en = 1'b1; mul_a = v_ff[1]; mul_b = v_ff[1];
            state_in = S_SQ_Z;
         end
         S_SQ_Z: begin
            sqyz_in = prod_ff;
            mul_en = 1'b1; mul_a = v_ff[2]; mul_b = v_ff[2];
            state_in = S_SQ_X;
         end
         S_SQ_X: begin
            sqyz_in = sqyz_ff + prod_ff;
            mul_en = 1'b1; mul_a = v_ff[0]; mul_b = v_ff[0];
            state_in = S_SQ_SUM;
         end
         S_SQ_SUM: begin
            sr_s_in   = sqyz_ff + prod_ff;
            sr_res_in = '0;
            cnt_in    = '0;
            ret_in    = S_N_CHK;
            state_in  = S_SQRT;
         end
         // One result bit of the integer square root per cycle.
         S_SQRT: begin
            if ({1'b0, sr_s_ff} >= sr_t) begin
               sr_s_in   = sr_s_ff - sr_t[63:0];
               sr_res_in = (sr_res_ff >> 1) + sr_bit;
            end else begin
               sr_res_in = sr_res_ff >> 1;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) state_in = ret_ff;
         end
         // One quotient bit of the restoring divider per cycle.
         S_DIV: begin
            dv_rem_in = dv_ge ? (dv_sh - {1'b0, dv_den_ff}) : dv_sh;
            dv_num_in = {dv_num_ff[62:0], dv_ge};
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ret_ff;
         end
         S_N_CHK: begin
            n_in = sr_res_ff[31:0];
            k_in = 2'd0;
            state_in = (sr_res_ff[31:0] == '0) ? S_CAL_END : S_B_MUL;
         end
         // Bias term v - v*G/n for each axis.
         S_B_MUL: begin
            mul_en = 1'b1; mul_a = v_ff[k_ff]; mul_b = GRAV_Q16;
            state_in = S_B_DIV;
         end
         S_B_DIV: begin
            dv_num_in = mag64(prod_ff); dv_neg_in = prod_ff < 0; dv_den_in = n_ff;
            dv_rem_in = '0; cnt_in = '0; ret_in = S_B_ACC; state_in = S_DIV;
         end
         S_B_ACC: begin
            sum_in[k_ff] = sum_ff[k_ff] + SUM_W'(v_ff[k_ff]) - q[SUM_W-1:0];
            if (k_ff == 2'd2) begin
               k_in      = 2'd0;
               idx_in    = idx_ff + CNT_W'(1);
               rd_ptr_in = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + PTR_W'(1);
               state_in  = (idx_ff == count_ff - CNT_W'(1)) ? S_M_SQRT : S_RD;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_B_MUL;
            end
         end
         // Newest sample: tilt norm of y and z.
         S_M_SQRT: begin
            sr_s_in = sqyz_ff; sr_res_in = '0; cnt_in = '0;
            ret_in  = S_M_CHK; state_in = S_SQRT;
         end
         S_M_CHK: begin
            m_in = sr_res_ff[31:0];
            k_in = 2'd0;
            state_in = (sr_res_ff[31:0] == '0) ? S_CAL_END : S_Z_DIV;
         end
         // Gravity axis z = v / n.
         S_Z_DIV: begin
            dv_num_in = mag64(64'(v_ff[k_ff])) << 14; dv_neg_in = v_ff[k_ff] < 0;
            dv_den_in = n_ff; dv_rem_in = '0; cnt_in = '0;
            ret_in = S_Z_ACC; state_in = S_DIV;
         end
         S_Z_ACC: begin
            z_in[k_ff] = clamp14(q);
            if (k_ff == 2'd2) begin
               k_in = 2'd1; state_in = S_W_DIV;
            end else begin
               k_in = k_ff + 2'd1; state_in = S_Z_DIV;
            end
         end
         // Unit vector of the y and z components.
         S_W_DIV: begin
            dv_num_in = mag64(64'(v_ff[k_ff])) << 14; dv_neg_in = v_ff[k_ff] < 0;
            dv_den_in = m_ff; dv_rem_in = '0; cnt_in = '0;
            ret_in = S_W_ACC; state_in = S_DIV;
         end
         S_W_ACC: begin
            if (k_ff == 2'd1) begin
               wy_in = clamp14(q); k_in = 2'd2; state_in = S_W_DIV;
            end else begin
               wz_in = clamp14(q); state_in = S_X0_DIV;
            end
         end
         // x axis from Gram-Schmidt of the unit x vector against z.
         S_X0_DIV: begin
            dv_num_in = 64'(m_ff) << 14; dv_neg_in = 1'b0;
            dv_den_in = n_ff; dv_rem_in = '0; cnt_in = '0;
            ret_in = S_X0_ACC; state_in = S_DIV;
         end
         S_X0_ACC: begin
            x_in[0] = clamp14(q);
            state_in = S_X1_MUL;
         end
         S_X1_MUL: begin
            mul_en = 1'b1; mul_a = 32'(z_ff[0]); mul_b = 32'(wy_ff);
            state_in = S_X1_ACC;
         end
         S_X1_ACC: begin
            x_in[1] = clamp14(-trunc14(65'(prod_ff)));
            mul_en = 1'b1; mul_a = 32'(z_ff[0]); mul_b = 32'(wz_ff);
            state_in = S_X2_ACC;
         end
         S_X2_ACC: begin
            x_in[2] = clamp14(-trunc14(65'(prod_ff)));
            k_in = 2'd0;
            state_in = S_Y_MUL1;
         end
         // y axis = z cross x, one component per pass.
         S_Y_MUL1: begin
            mul_en = 1'b1;
            case (k_ff)
               2'd0:    begin mul_a = 32'(z_ff[1]); mul_b = 32'(x_ff[2]); end
               2'd1:    begin mul_a = 32'(z_ff[2]); mul_b = 32'(x_ff[0]); end
               default: begin mul_a = 32'(z_ff[0]); mul_b = 32'(x_ff[1]); end
            endcase
            state_in = S_Y_MUL2;
         end
         S_Y_MUL2: begin
            cross_in = prod_ff;
            mul_en = 1'b1;
            case (k_ff)
               2'd0:    begin mul_a = 32'(z_ff[2]); mul_b = 32'(x_ff[1]); end
               2'd1:    begin mul_a = 32'(z_ff[0]); mul_b = 32'(x_ff[2]); end
               default: begin mul_a = 32'(z_ff[1]); mul_b = 32'(x_ff[0]); end
            endcase
            state_in = S_Y_ACC;
         end
         S_Y_ACC: begin
            y_in[k_ff] = clamp14(trunc14(65'(cross_ff - prod_ff)));
            if (k_ff == 2'd2) begin
               k_in = 2'd0; state_in = S_A_DIV;
            end else begin
               k_in = k_ff + 2'd1; state_in = S_Y_MUL1;
            end
         end
         // Average bias = sum / count.
         S_A_DIV: begin
            dv_num_in = mag64(64'(sum_ff[k_ff])); dv_neg_in = sum_ff[k_ff] < 0;
            dv_den_in = 32'(count_ff); dv_rem_in = '0; cnt_in = '0;
            ret_in = S_A_ACC; state_in = S_DIV;
         end
         S_A_ACC: begin
            bias_in[k_ff] = sat32(q);
            if (k_ff == 2'd2) begin
               state_in = S_CAL_END;
            end else begin
               k_in = k_ff + 2'd1; state_in = S_A_DIV;
            end
         end
         S_CAL_END: begin
            head_in  = '0;
            count_in = '0;
            state_in = S_EMIT;
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = mul_en ? 64'(mul_a * mul_b) : prod_ff;
   end

   // Control registers and committed results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         storing_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            x_ff[i]    <= '0;
            y_ff[i]    <= '0;
            z_ff[i]    <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         storing_ff   <= storing_in;
         pending_ff   <= pending_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         bias_ff      <= bias_in;
      end
   end

   // Working registers of the calibration datapath.
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      cross_ff    <= cross_in;
      sqyz_ff     <= sqyz_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      sum_ff      <= sum_in;
      wy_ff       <= wy_in;
      wz_ff       <= wz_in;
      dv_num_ff   <= dv_num_in;
      dv_rem_ff   <= dv_rem_in;
      dv_den_ff   <= dv_den_in;
      dv_neg_ff   <= dv_neg_in;
      sr_s_ff     <= sr_s_in;
      sr_res_ff   <= sr_res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sample ring: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[wr_addr] <= req_tdata;
      if (mem_re) rd_data_ff <= ring_mem[rd_ptr_ff];
   end

endmodule

FILE: tb/tb_accel_gravity_bias_calibrator.sv
// Self-checking testbench for the accelerometer gravity and bias calibrator.
// Depends on rtl/core/gbc_pkg.sv and rtl/core/accel_gravity_bias_calibrator.sv.
// A built-in predictor computes each expected result and a checker compares every output.
module tb_accel_gravity_bias_calibrator;
   import gbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = 1024;
   localparam int DROP = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = KIND_SAMPLE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [239:0] rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [9:0]   csr_wr_data = '0;

   accel_gravity_bias_calibrator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Predictor state: a private copy of the block's ring, flags and outputs.
   int          ring_x [RING];
   int          ring_y [RING];
   int          ring_z [RING];
   int unsigned ring_head;
   int unsigned ring_count;
   bit          storing;
   bit          calib_armed;
   int          rot [3][3];
   int          bias [3];
   logic [9:0]  sample_limit;
   int          calib_busy_cycles;

   logic [239:0] outputs_due [$];
   int           error_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           stall_left;
   bit           hold_request;

   function automatic longint unsigned isqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned square(longint v);
      return longint'(v * v);
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > ONE_Q14) return ONE_Q14;
      if (v < -ONE_Q14) return -ONE_Q14;
      return v;
   endfunction

   function automatic int sat_word(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // Averages the bias over the ring and rebuilds the gravity frame from the
   // newest sample; any degenerate case keeps the previous outputs.
   task automatic recompute_gravity_frame();
      longint sum [3];
      longint v [3];
      longint za [3];
      longint xa [3];
      longint ya [3];
      longint n;
      longint m;
      longint wy;
      longint wz;
      longint grav;
      int unsigned idx;
      grav = longint'(GRAV_Q16);
      for (int k = 0; k < 3; k++) begin
         sum[k] = 0;
         v[k] = 0;
      end
      n = 0;
      if (ring_count == 0) return;
      for (int unsigned i = 0; i < ring_count; i++) begin
         idx = (ring_head + i) % RING;
         v[0] = ring_x[idx];
         v[1] = ring_y[idx];
         v[2] = ring_z[idx];
         n = longint'(isqrt(square(v[0]) + square(v[1]) + square(v[2])));
         if (n == 0) return;
         for (int k = 0; k < 3; k++) sum[k] += v[k] - (v[k] * grav) / n;
      end
      m = longint'(isqrt(square(v[1]) + square(v[2])));
      if (m == 0) return;
      for (int k = 0; k < 3; k++) za[k] = clamp_unit((v[k] * ONE_Q14) / n);
      wy = clamp_unit((v[1] * ONE_Q14) / m);
      wz = clamp_unit((v[2] * ONE_Q14) / m);
      xa[0] = clamp_unit((m * ONE_Q14) / n);
      xa[1] = clamp_unit(-((za[0] * wy) / ONE_Q14));
      xa[2] = clamp_unit(-((za[0] * wz) / ONE_Q14));
      ya[0] = clamp_unit((za[1] * xa[2] - za[2] * xa[1]) / ONE_Q14);
      ya[1] = clamp_unit((za[2] * xa[0] - za[0] * xa[2]) / ONE_Q14);
      ya[2] = clamp_unit((za[0] * xa[1] - za[1] * xa[0]) / ONE_Q14);
      for (int k = 0; k < 3; k++) begin
         rot[k][0] = int'(xa[k]);
         rot[k][1] = int'(ya[k]);
         rot[k][2] = int'(za[k]);
         bias[k] = sat_word(sum[k] / longint'(ring_count));
      end
   endtask

   // Applies one accepted transaction to the predictor and queues any output.
   task automatic predict_calibrator(kind_type kind, int ax, int ay, int az);
      int unsigned lim;
      int unsigned idx;
      int unsigned drop;
      bit rot_nz;
      bit bias_nz;
      logic [239:0] word;
      case (kind)
         KIND_START: begin
            storing = 1'b1;
            return;
         end
         KIND_STOP: begin
            storing = 1'b0;
            return;
         end
         KIND_CALIB: begin
            calib_armed = 1'b1;
            return;
         end
         default: ;
      endcase
      if (storing) begin
         lim = sample_limit;
         if (lim > RING - 1) lim = RING - 1;
         idx = (ring_head + ring_count) % RING;
         ring_x[idx] = ax;
         ring_y[idx] = ay;
         ring_z[idx] = az;
         ring_count++;
         if (ring_count > lim) begin
            drop = (ring_count < DROP) ? ring_count : DROP;
            ring_head = (ring_head + drop) % RING;
            ring_count -= drop;
         end
      end
      if (calib_armed) begin
         calib_armed = 1'b0;
         calib_busy_cycles = ring_count * 300 + 1500;
         recompute_gravity_frame();
         ring_head = 0;
         ring_count = 0;
      end
      rot_nz = 1'b0;
      bias_nz = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) if (rot[r][c] != 0) rot_nz = 1'b1;
         if (bias[r] != 0) bias_nz = 1'b1;
      end
      if (!rot_nz || !bias_nz) return;
      word = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) word[16*(r*3+c) +: 16] = rot[c][r][15:0];
         word[144 + 32*r +: 32] = bias[r];
      end
      outputs_due.push_back(word);
   endtask

   // Offers one transaction, waits for the handshake and updates the predictor.
   task automatic send_event(kind_type kind, int ax = 0, int ay = 0, int az = 0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {az, ay, ax};
      do @(posedge clock); while (!req_tready);
      predict_calibrator(kind, ax, ay, az);
   endtask

   task automatic send_sample(int ax, int ay, int az);
      send_event(KIND_SAMPLE, ax, ay, az);
   endtask

   // Stops offering until every predicted output has been taken.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outputs_due.size() != 0);
   endtask

   // Waits for the block to go idle, then writes the sample limit.
   task automatic write_sample_limit(logic [9:0] value);
      drain_outputs();
      repeat (calib_busy_cycles) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sample_limit = value;
   endtask

   // Draws one random sample: full range, small values, near one g, or zero.
   task automatic random_sample(output int ax, output int ay, output int az);
      case ($urandom_range(9))
         0, 1: begin
            ax = $urandom;
            ay = $urandom;
            az = $urandom;
         end
         2: begin
            ax = 0;
            ay = 0;
            az = ($urandom_range(39) == 0) ? 0 : int'($urandom_range(2000)) - 1000;
         end
         3, 4, 5: begin
            ax = int'($urandom_range(2097152)) - 1048576;
            ay = int'($urandom_range(2097152)) - 1048576;
            az = int'($urandom_range(2097152)) - 1048576;
         end
         default: begin
            ax = int'($urandom_range(131072)) - 65536;
            ay = int'($urandom_range(131072)) - 65536;
            az = 642908 + int'($urandom_range(131072)) - 65536;
         end
      endcase
   endtask

   // Reset behavior, every event kind, field extremes and the degenerate cases.
   task automatic test_directed();
      send_sample(642908, 0, 0);
      send_event(KIND_START, 32'h7fffffff, 32'h80000000, 32'h55555555);
      send_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_sample(32'h80000000, 32'h80000000, 32'h80000000);
      send_sample(32'h7fffffff, 32'h80000000, 1);
      send_sample(-1, -1, -1);
      send_event(KIND_STOP);
      send_sample(100000, 200000, 300000);
      send_event(KIND_CALIB);
      send_sample(100000, -200000, 600000);
      send_sample(0, 0, 642908);
      send_sample(0, 0, 0);
      // A zero-norm sample in the ring keeps the previous frame.
      send_event(KIND_START);
      send_sample(0, 0, 0);
      send_sample(5000, 6000, 640000);
      send_event(KIND_CALIB);
      send_sample(-5000, 7000, 650000);
      // Calibration with an empty ring keeps the previous frame.
      send_event(KIND_STOP);
      send_event(KIND_CALIB);
      send_sample(1, 2, 3);
      // The newest sample along the x axis is degenerate.
      send_event(KIND_START);
      send_sample(3000, 4000, 640000);
      send_event(KIND_CALIB);
      send_sample(5 << 16, 0, 0);
      send_sample(32'h80000000, 32'h7fffffff, 0);
      drain_outputs();
   endtask

   // Runs one store-and-calibrate sequence, storing n samples before the calibrate event.
   task automatic calibrate_after(int n);
      int ax;
      int ay;
      int az;
      send_event(KIND_START);
      for (int i = 0; i < n; i++) begin
         random_sample(ax, ay, az);
         send_sample(ax, ay, az);
      end
      send_event(KIND_CALIB);
      random_sample(ax, ay, az);
      send_sample(ax, ay, az);
      send_sample(ax, az, ay);
   endtask

   // Sample limit at zero, one, the maximum and across the hundred-entry drop.
   task automatic test_limits();
      write_sample_limit(10'd0);
      calibrate_after(5);
      write_sample_limit(10'd1);
      calibrate_after(4);
      write_sample_limit(10'd1023);
      calibrate_after(20);
      write_sample_limit(10'd150);
      calibrate_after(170);
      drain_outputs();
   endtask

   // Mostly well-formed calibration sequences, with stray events mixed in.
   task automatic test_random(int n_items, bit with_hold);
      int sent;
      int ax;
      int ay;
      int az;
      int n;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            random_sample(ax, ay, az);
            send_event(kind_type'($urandom_range(3)), ax, ay, az);
            sent++;
         end else begin
            n = $urandom_range(1, 25);
            send_event(KIND_START);
            sent++;
            for (int i = 0; i < n; i++) begin
               random_sample(ax, ay, az);
               if ($urandom_range(19) == 0) begin
                  send_event(KIND_STOP, ax, ay, az);
                  sent++;
               end else if ($urandom_range(19) == 0) begin
                  send_event(KIND_START, ax, ay, az);
                  sent++;
               end
               send_sample(ax, ay, az);
               sent++;
            end
            send_event(KIND_CALIB);
            sent++;
            n = $urandom_range(3, 15);
            for (int i = 0; i < n; i++) begin
               random_sample(ax, ay, az);
               send_sample(ax, ay, az);
               sent++;
            end
            // Hold off the receiver while intake keeps going.
            if (with_hold && sent > n_items / 2) begin
               hold_request = 1'b1;
               with_hold = 1'b0;
            end
         end
      end
   endtask

   // Receiver side: random stalls plus an occasional long hold-off.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left <= 3000;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compares each output transaction field by field with the oldest prediction.
   always @(posedge clock) begin
      logic [239:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outputs_due.size() == 0) begin
            $display("%0t: unexpected output, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = outputs_due.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (rsp_tdata[16*i +: 16] !== want[16*i +: 16]) begin
                  $display("%0t: rot_%0d%0d expected %0d, actual %0d", $time, i / 3, i % 3,
                           $signed(want[16*i +: 16]), $signed(rsp_tdata[16*i +: 16]));
                  error_count++;
               end
            end
            for (int i = 0; i < 3; i++) begin
               if (rsp_tdata[144 + 32*i +: 32] !== want[144 + 32*i +: 32]) begin
                  $display("%0t: bias_%0d expected %0d, actual %0d", $time, i,
                           $signed(want[144 + 32*i +: 32]),
                           $signed(rsp_tdata[144 + 32*i +: 32]));
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      ring_head = 0;
      ring_count = 0;
      storing = 1'b0;
      calib_armed = 1'b0;
      for (int k = 0; k < 3; k++) begin
         bias[k] = 0;
         for (int j = 0; j < 3; j++) rot[k][j] = 0;
      end
      sample_limit = LIMIT_RESET;
      calib_busy_cycles = 100;
      error_count = 0;
      stall_left = 0;
      hold_request = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 86;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_limits();
      write_sample_limit(10'($urandom_range(1, 40)));
      test_random(220, 1'b1);
      send_idle_pct = 86;
      recv_idle_pct = 23;
      write_sample_limit(10'($urandom_range(1, 40)));
      test_random(220, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_sample_limit(10'($urandom_range(1, 40)));
      test_random(220, 1'b0);

      drain_outputs();
      repeat (calib_busy_cycles) @(posedge clock);
      if (error_count == 0 && outputs_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
